>>> rtl/semi_pkg.sv
package semi_pkg;

  localparam int SERVO_COUNT_DEF = 7;
  localparam int EASE_FRAC_DEF = 16;
  localparam int MAX_SERVOS = 7;
  localparam int ANGLE_W = 8;
  localparam int TIME_W = 20;
  localparam int PACK_W = 56;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 56;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
  localparam logic [ANGLE_W-1:0] ANGLE_LIMIT = 8'd180;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_PACK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PACK = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_PACK = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DUR = 3'd4;

  localparam logic [PACK_W-1:0] MIN_PACK_RST = 56'd15547095261863680;
  localparam logic [PACK_W-1:0] MAX_PACK_RST = 56'd43827309609006260;
  localparam logic [7:0] SPEED_RST = 8'd10;
  localparam logic [15:0] MIN_DUR_RST = 16'd200;

  localparam logic [MAX_SERVOS*ANGLE_W-1:0] NEUTRAL_PACK =
    {8'd100, 8'd120, 8'd70, 8'd100, 8'd130, 8'd130, 8'd90};

  typedef struct packed {
    logic load;
    logic check;
    logic scan;
    logic start_div;
    logic calc;
    logic jump;
    logic arm;
    logic finish;
    logic tick_adv;
  } dp_cmd_t;

  typedef struct packed {
    logic limit_bad;
    logic dur_zero;
    logic div_done;
    logic move_ends;
    logic moving;
  } dp_stat_t;

endpackage

>>> rtl/semi_divider.sv
module semi_divider #(
  parameter int NUM_W = 36,
  parameter int DEN_W = 20
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] numer,
  input  logic [DEN_W-1:0] denom,
  output logic [NUM_W-1:0] quot,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_sh;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;

  always_comb begin
    trial = {rem[DEN_W-1:0], num_sh[NUM_W-1]};
    diff = {1'b0, trial} - {2'b00, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_sh <= numer;
      rem    <= '0;
      den    <= denom;
      quot   <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[NUM_W-2:0], 1'b0};
      if (!diff[DEN_W+1]) begin
        rem  <= diff[DEN_W:0];
        quot <= {quot[NUM_W-2:0], 1'b1};
      end else begin
        rem  <= trial;
        quot <= {quot[NUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/semi_datapath.sv
module semi_datapath #(
  parameter int SERVO_COUNT = semi_pkg::SERVO_COUNT_DEF,
  parameter int EASE_FRACTION_BITS = semi_pkg::EASE_FRAC_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  semi_pkg::dp_cmd_t                 cmd,
  output semi_pkg::dp_stat_t                stat,
  input  logic [$clog2(SERVO_COUNT+1)-1:0]  sel,
  input  logic [2:0]                        in_servo,
  input  logic [semi_pkg::ANGLE_W-1:0]      in_angle,
  input  logic [semi_pkg::TIME_W-1:0]       in_dur,
  input  logic                              in_use_speed,
  input  logic                              cfg_valid,
  input  logic [semi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [semi_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic [semi_pkg::ANGLE_W-1:0]      sel_angle
);

  localparam int F = EASE_FRACTION_BITS;
  localparam int AW = semi_pkg::ANGLE_W;
  localparam int TW = semi_pkg::TIME_W;
  localparam int IW = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
  localparam int NUM_W = TW + F;

  logic [semi_pkg::PACK_W-1:0] min_pack;
  logic [semi_pkg::PACK_W-1:0] max_pack;
  logic [semi_pkg::PACK_W-1:0] off_pack;
  logic [7:0]                  speed;
  logic [15:0]                 min_dur;

  logic [AW-1:0] current [SERVO_COUNT];
  logic [AW-1:0] pending [SERVO_COUNT];
  logic [AW-1:0] start_a [SERVO_COUNT];
  logic [AW-1:0] goal_a  [SERVO_COUNT];
  logic          moving;
  logic [TW-1:0] elapsed;
  logic [TW-1:0] length;
  logic [AW-1:0] maxd;
  logic          bad;
  logic [TW-1:0] dur;
  logic [F:0]    ease;

  logic [IW-1:0]   idx;
  logic [AW-1:0]   cur_s;
  logic [AW-1:0]   pend_s;
  logic [AW-1:0]   mn_s;
  logic [AW-1:0]   mx_s;
  logic [AW-1:0]   absd;
  logic [NUM_W-1:0] quot;
  logic            div_done;
  logic [F:0]      p_sat;
  logic [F:0]      q;
  logic [2*F+1:0]  sq;
  logic [F:0]      ease_next;
  logic [AW:0]     dlt;
  logic [AW+F+2:0] prod;
  logic [AW+F+2:0] total;
  logic [TW-1:0]   spd_dur;
  logic [TW-1:0]   elapsed_inc;
  logic signed [AW+1:0] corr;

  assign idx = sel[IW-1:0];

  always_comb begin
    cur_s  = current[idx];
    pend_s = pending[idx];
    mn_s   = min_pack[idx*AW +: AW];
    mx_s   = max_pack[idx*AW +: AW];
    absd   = (pend_s >= cur_s) ? pend_s - cur_s : cur_s - pend_s;
    spd_dur = TW'(maxd) * TW'(speed);
    if (spd_dur < TW'(min_dur)) spd_dur = TW'(min_dur);
    p_sat = (quot > NUM_W'(1 << F)) ? (F+1)'(1 << F) : quot[F:0];
    q = p_sat[F-1] | p_sat[F] ? (F+1)'(1 << F) - p_sat : p_sat;
    sq = q * q;
    if (p_sat[F-1] | p_sat[F]) ease_next = (F+1)'(1 << F) - sq[2*F-1:F-1];
    else ease_next = sq[2*F-1:F-1];
    dlt = {1'b0, goal_a[idx]} - {1'b0, start_a[idx]};
    prod = $signed({{(F+2){dlt[AW]}}, dlt}) * $signed({2'b00, ease});
    total = {3'b000, start_a[idx], {F{1'b0}}} + prod;
    elapsed_inc = (elapsed == semi_pkg::TIME_MAX) ? elapsed : elapsed + 1'b1;
    corr = $signed({2'b00, current[idx]}) +
           $signed({{2{off_pack[idx*AW+AW-1]}}, off_pack[idx*AW +: AW]});
    if (corr < 0) sel_angle = '0;
    else if (corr > $signed({2'b00, semi_pkg::ANGLE_LIMIT})) sel_angle = semi_pkg::ANGLE_LIMIT;
    else sel_angle = corr[AW-1:0];
  end

  semi_divider #(.NUM_W(NUM_W), .DEN_W(TW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.start_div),
    .numer ({elapsed, {F{1'b0}}}),
    .denom (length),
    .quot  (quot),
    .done  (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      min_pack <= semi_pkg::MIN_PACK_RST;
      max_pack <= semi_pkg::MAX_PACK_RST;
      off_pack <= '0;
      speed    <= semi_pkg::SPEED_RST;
      min_dur  <= semi_pkg::MIN_DUR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        semi_pkg::REG_MIN_PACK:    min_pack <= cfg_data;
        semi_pkg::REG_MAX_PACK:    max_pack <= cfg_data;
        semi_pkg::REG_OFFSET_PACK: off_pack <= cfg_data;
        semi_pkg::REG_SPEED:       speed <= cfg_data[7:0];
        semi_pkg::REG_MIN_DUR:     min_dur <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SERVO_COUNT; i++) begin
        current[i] <= semi_pkg::NEUTRAL_PACK[i*AW +: AW];
        pending[i] <= semi_pkg::NEUTRAL_PACK[i*AW +: AW];
      end
      moving  <= 1'b0;
      elapsed <= '0;
      length  <= '0;
      maxd    <= '0;
      bad     <= 1'b0;
      dur     <= '0;
      ease    <= '0;
    end else begin
      if (cmd.load) begin
        if (32'(in_servo) < SERVO_COUNT) pending[in_servo[IW-1:0]] <= in_angle;
        bad  <= 1'b0;
        maxd <= '0;
      end
      if (cmd.check) begin
        if (pend_s < mn_s || pend_s > mx_s) bad <= 1'b1;
        if (absd > maxd) maxd <= absd;
      end
      if (cmd.scan) dur <= in_use_speed ? spd_dur : in_dur;
      if (cmd.jump) begin
        for (int i = 0; i < SERVO_COUNT; i++) current[i] <= pending[i];
        moving <= 1'b0;
      end
      if (cmd.arm) begin
        for (int i = 0; i < SERVO_COUNT; i++) begin
          start_a[i] <= current[i];
          goal_a[i]  <= pending[i];
        end
        elapsed <= '0;
        length  <= dur;
        moving  <= 1'b1;
      end
      if (cmd.tick_adv) elapsed <= elapsed_inc;
      if (div_done) ease <= ease_next;
      if (cmd.calc) current[idx] <= total[F +: AW];
      if (cmd.finish) begin
        for (int i = 0; i < SERVO_COUNT; i++) current[i] <= goal_a[i];
        moving <= 1'b0;
      end
    end
  end

  assign stat.limit_bad = bad;
  assign stat.dur_zero  = (dur == '0);
  assign stat.div_done  = div_done;
  assign stat.move_ends = (elapsed >= length) || (length == '0);
  assign stat.moving    = moving;

endmodule

>>> rtl/semi_ctrl.sv
module semi_ctrl #(
  parameter int SERVO_COUNT = semi_pkg::SERVO_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_tick,
  input  logic                             in_last,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_status,
  output logic                             out_last,
  output logic                             out_moving,
  output logic [$clog2(SERVO_COUNT+1)-1:0] sel,
  output semi_pkg::dp_cmd_t                cmd,
  input  semi_pkg::dp_stat_t               stat
);

  localparam int SW = $clog2(SERVO_COUNT + 1);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHECK  = 4'd1;
  localparam logic [3:0] S_DUR    = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_TICK   = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_CALC   = 4'd6;
  localparam logic [3:0] S_EMIT   = 4'd7;
  localparam logic [3:0] S_REJECT = 4'd8;
  localparam logic [3:0] S_WAIT   = 4'd9;

  logic [3:0]    state;
  logic [3:0]    state_next;
  logic [SW-1:0] cnt;
  logic [SW-1:0] cnt_next;
  logic          acc;
  logic          out_fire;

  assign acc = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = (state != S_IDLE);
  assign sel = cnt;

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    out_valid = 1'b0;
    out_status = 1'b0;
    out_last = 1'b0;
    out_moving = stat.moving;
    unique case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (acc) begin
          if (in_tick) begin
            if (stat.moving) begin
              cmd.tick_adv = 1'b1;
              state_next = S_TICK;
            end
          end else begin
            cmd.load = 1'b1;
            if (in_last) state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == SW'(SERVO_COUNT - 1)) state_next = S_DUR;
      end
      S_DUR: begin
        cnt_next = '0;
        if (stat.limit_bad) state_next = S_REJECT;
        else begin
          cmd.scan = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.dur_zero) begin
          cmd.jump = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.arm = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: state_next = S_IDLE;
      S_TICK: begin
        if (stat.move_ends) begin
          cmd.finish = 1'b1;
          state_next = S_EMIT;
        end else begin
          cmd.start_div = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: if (stat.div_done) state_next = S_CALC;
      S_CALC: begin
        cmd.calc = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == SW'(SERVO_COUNT - 1)) begin
          cnt_next = '0;
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        out_valid = 1'b1;
        out_last = (cnt == SW'(SERVO_COUNT - 1));
        if (out_fire) begin
          cnt_next = cnt + 1'b1;
          if (out_last) state_next = S_IDLE;
        end
      end
      S_REJECT: begin
        out_valid = 1'b1;
        out_status = 1'b1;
        out_last = 1'b1;
        if (out_fire) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

endmodule

>>> rtl/servo_ease_motion_interpolator_top.sv
// Eased multi-servo trajectory interpolator.
// Input channel (in_valid/in_stall): a load beat (req_type 0) stores one
// servo target; with last_target set it commits the move. A tick beat
// (req_type 1) advances a running move by one millisecond.
// Output channel (out_valid/out_stall): one beat per servo, servo 0 first,
// last_of_run on the final beat; a rejected commit gives one status beat.
// Configuration (cfg_valid/cfg_ready): always ready; write while idle.
// A commit checks each servo against its limits in turn, then fixes
// the duration and either jumps (zero duration) or arms the move. A
// tick that does not end the move runs the bit-serial divider, then the
// shared multiplier once per servo, then gives the beats. One item is
// worked at a time.
// Reset restores neutral angles and default limits; no move is running.
// A stalled receiver holds the current beat; in_stall stays high meanwhile.
module servo_ease_motion_interpolator_top #(
  parameter int SERVO_COUNT = semi_pkg::SERVO_COUNT_DEF,
  parameter int EASE_FRACTION_BITS = semi_pkg::EASE_FRAC_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            req_type,
  input  logic [2:0]                      servo_index,
  input  logic [7:0]                      target_angle,
  input  logic [19:0]                     duration_ms,
  input  logic                            use_speed,
  input  logic                            last_target,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            status,
  output logic [2:0]                      out_servo,
  output logic [7:0]                      command_angle,
  output logic                            still_moving,
  output logic                            last_of_run,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [semi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [semi_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int SW = $clog2(SERVO_COUNT + 1);

  semi_pkg::dp_cmd_t  cmd;
  semi_pkg::dp_stat_t stat;
  logic [SW-1:0]      sel;
  logic [7:0]         sel_angle;
  logic               use_speed_q;
  logic [19:0]        dur_q;
  logic               st;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      use_speed_q <= use_speed;
      dur_q <= duration_ms;
    end
  end

  semi_ctrl #(.SERVO_COUNT(SERVO_COUNT)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_tick    (req_type),
    .in_last    (last_target),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (st),
    .out_last   (last_of_run),
    .out_moving (still_moving),
    .sel        (sel),
    .cmd        (cmd),
    .stat       (stat)
  );

  semi_datapath #(
    .SERVO_COUNT(SERVO_COUNT),
    .EASE_FRACTION_BITS(EASE_FRACTION_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sel          (sel),
    .in_servo     (servo_index),
    .in_angle     (target_angle),
    .in_dur       (dur_q),
    .in_use_speed (use_speed_q),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sel_angle    (sel_angle)
  );

  assign status = st;
  assign out_servo = st ? 3'd0 : 3'(sel);
  assign command_angle = st ? 8'd0 : sel_angle;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken during output");
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> last_of_run) else $error("status beat not last");
  a_hold_beat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_servo)))
    else $error("stalled beat changed");

endmodule

>>> test/servo_ease_motion_checker.sv
`timescale 1ns / 100ps
module servo_ease_motion_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            req_type,
  input  logic [2:0]                      servo_index,
  input  logic [7:0]                      target_angle,
  input  logic [19:0]                     duration_ms,
  input  logic                            use_speed,
  input  logic                            last_target,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic                            status,
  input  logic [2:0]                      out_servo,
  input  logic [7:0]                      command_angle,
  input  logic                            still_moving,
  input  logic                            last_of_run,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [semi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [semi_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              outstanding
);

  localparam int NS = semi_pkg::SERVO_COUNT_DEF;
  localparam int FB = semi_pkg::EASE_FRAC_DEF;
  localparam int PW = semi_pkg::PACK_W;

  typedef struct packed {
    logic       status;
    logic [2:0] servo;
    logic [7:0] angle;
    logic       moving;
    logic       last;
  } servo_beat_t;

  servo_beat_t cmd_q[$];

  logic [PW-1:0]     lo_pack, hi_pack, trim_pack;
  logic [7:0]        ms_per_deg;
  logic [15:0]       dur_floor;
  logic [7:0]        cur_ang[NS], from_ang[NS], to_ang[NS], pend_ang[NS];
  logic              in_motion;
  logic [19:0]       elapsed, span;

  function automatic logic [7:0] trimmed(int i, logic [7:0] a);
    int v;
    v = int'(a) + int'($signed(trim_pack[8*i +: 8]));
    if (v < 0) v = 0;
    if (v > 180) v = 180;
    return v[7:0];
  endfunction

  function automatic longint eased(longint p);
    longint q;
    if (p > (64'd1 << FB)) p = 64'd1 << FB;
    if (p < (64'd1 << (FB - 1))) return (p * p) >>> (FB - 1);
    q = (64'd1 << FB) - p;
    return (64'd1 << FB) - ((q * q) >>> (FB - 1));
  endfunction

  task automatic push_all();
    servo_beat_t b;
    for (int i = 0; i < NS; i++) begin
      b.status = 1'b0;
      b.servo = i[2:0];
      b.angle = trimmed(i, cur_ang[i]);
      b.moving = in_motion;
      b.last = (i == NS - 1);
      cmd_q.push_back(b);
    end
  endtask

  task automatic advance_tick();
    longint p, e, tot;
    if (!in_motion) return;
    if (elapsed != semi_pkg::TIME_MAX) elapsed++;
    if (elapsed >= span || span == 0) begin
      for (int i = 0; i < NS; i++) cur_ang[i] = to_ang[i];
      in_motion = 1'b0;
      push_all();
      return;
    end
    p = (longint'(elapsed) << FB) / longint'(span);
    e = eased(p);
    for (int i = 0; i < NS; i++) begin
      tot = longint'(from_ang[i]) * (64'd1 << FB)
          + (longint'(to_ang[i]) - longint'(from_ang[i])) * e;
      if (tot < 0) tot = 0;
      cur_ang[i] = tot[FB +: 8];
    end
    push_all();
  endtask

  task automatic commit_move(logic [19:0] dur_in, logic by_speed);
    logic        bad;
    int          d, maxd;
    logic [31:0] dur;
    servo_beat_t b;
    bad = 1'b0;
    for (int i = 0; i < NS; i++)
      if (pend_ang[i] < lo_pack[8*i +: 8] || pend_ang[i] > hi_pack[8*i +: 8]) bad = 1'b1;
    if (bad) begin
      b = '0;
      b.status = 1'b1;
      b.moving = in_motion;
      b.last = 1'b1;
      cmd_q.push_back(b);
      return;
    end
    if (by_speed) begin
      maxd = 0;
      for (int i = 0; i < NS; i++) begin
        d = int'(pend_ang[i]) - int'(cur_ang[i]);
        if (d < 0) d = -d;
        if (d > maxd) maxd = d;
      end
      dur = maxd * ms_per_deg;
      if (dur < dur_floor) dur = 32'(dur_floor);
    end else begin
      dur = 32'(dur_in);
    end
    if (dur == 0) begin
      for (int i = 0; i < NS; i++) cur_ang[i] = pend_ang[i];
      in_motion = 1'b0;
      push_all();
      return;
    end
    for (int i = 0; i < NS; i++) begin
      from_ang[i] = cur_ang[i];
      to_ang[i] = pend_ang[i];
    end
    elapsed = '0;
    span = dur[19:0];
    in_motion = 1'b1;
  endtask

  servo_beat_t got, want;

  always @(posedge clk) begin
    if (rst) begin
      lo_pack = semi_pkg::MIN_PACK_RST;
      hi_pack = semi_pkg::MAX_PACK_RST;
      trim_pack = '0;
      ms_per_deg = semi_pkg::SPEED_RST;
      dur_floor = semi_pkg::MIN_DUR_RST;
      for (int i = 0; i < NS; i++) begin
        cur_ang[i] = semi_pkg::NEUTRAL_PACK[8*i +: 8];
        pend_ang[i] = semi_pkg::NEUTRAL_PACK[8*i +: 8];
        from_ang[i] = '0;
        to_ang[i] = '0;
      end
      in_motion = 1'b0;
      elapsed = '0;
      span = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          semi_pkg::REG_MIN_PACK:    lo_pack = cfg_data[PW-1:0];
          semi_pkg::REG_MAX_PACK:    hi_pack = cfg_data[PW-1:0];
          semi_pkg::REG_OFFSET_PACK: trim_pack = cfg_data[PW-1:0];
          semi_pkg::REG_SPEED:       ms_per_deg = cfg_data[7:0];
          semi_pkg::REG_MIN_DUR:     dur_floor = cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got = {status, out_servo, command_angle, still_moving, last_of_run};
        if (cmd_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected beat st=%0d servo=%0d ang=%0d mv=%0d last=%0d",
                     $realtime, status, out_servo, command_angle, still_moving, last_of_run);
        end else begin
          want = cmd_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"%0t: mismatch exp st=%0d servo=%0d ang=%0d mv=%0d last=%0d",
                        " / got st=%0d servo=%0d ang=%0d mv=%0d last=%0d"},
                       $realtime, want.status, want.servo, want.angle, want.moving,
                       want.last, status, out_servo, command_angle, still_moving,
                       last_of_run);
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (req_type) begin
          advance_tick();
        end else begin
          if (servo_index < NS) pend_ang[servo_index] = target_angle;
          if (last_target) commit_move(duration_ms, use_speed);
        end
      end
    end
    outstanding = cmd_q.size();
  end

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

endmodule

>>> test/tb_servo_ease_motion_interpolator_top.sv
`timescale 1ns / 100ps
module tb_servo_ease_motion_interpolator_top;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic                            req_type = 1'b0;
  logic [2:0]                      servo_index = '0;
  logic [7:0]                      target_angle = '0;
  logic [19:0]                     duration_ms = '0;
  logic                            use_speed = 1'b0;
  logic                            last_target = 1'b0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic                            status;
  logic [2:0]                      out_servo;
  logic [7:0]                      command_angle;
  logic                            still_moving;
  logic                            last_of_run;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [semi_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [semi_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  int                              fail_count;
  int                              outstanding;

  logic                        calm = 1'b0;
  int                          long_hold = 0;
  int                          stall_left = 0;
  logic                        beat_taken = 1'b0;
  logic [semi_pkg::PACK_W-1:0] lo_copy = semi_pkg::MIN_PACK_RST;
  logic [semi_pkg::PACK_W-1:0] hi_copy = semi_pkg::MAX_PACK_RST;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  servo_ease_motion_interpolator_top dut (.*);

  servo_ease_motion_checker chk (.*);

  always @(posedge clk) beat_taken <= out_valid && !out_stall;

  always @(negedge clk) begin
    if (beat_taken) stall_left = calm ? 0 : $urandom_range(0, 9);
    if (long_hold > 0) begin
      long_hold--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send(logic rt, logic [2:0] idx, logic [7:0] ang, logic [19:0] dur,
                      logic spd, logic lst);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_type <= rt;
    servo_index <= idx;
    target_angle <= ang;
    duration_ms <= dur;
    use_speed <= spd;
    last_target <= lst;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic tick_n(int n);
    repeat (n) send(1'b1, 3'($urandom), 8'($urandom), 20'($urandom), 1'($urandom),
                    1'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    wait (outstanding == 0);
    repeat (64) @(negedge clk);
  endtask

  task automatic write_reg(logic [semi_pkg::CFG_IDX_W-1:0] idx,
                           logic [semi_pkg::CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    if (idx == semi_pkg::REG_MIN_PACK) lo_copy = val;
    if (idx == semi_pkg::REG_MAX_PACK) hi_copy = val;
  endtask

  function automatic logic [7:0] legal_angle(int i);
    int lo, hi;
    lo = int'(lo_copy[8*i +: 8]);
    hi = int'(hi_copy[8*i +: 8]);
    if ($urandom_range(0, 9) == 0 || lo > hi) return 8'($urandom);
    return 8'($urandom_range(lo, hi));
  endfunction

  task automatic random_moves(int count);
    int          sent, loads, pick, idx;
    logic [19:0] dur;
    logic        spd;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send(1'b0, 3'($urandom), 8'($urandom), 20'($urandom), 1'($urandom), 1'($urandom));
        sent++;
      end else begin
        loads = $urandom_range(1, 7);
        for (int k = 0; k < loads; k++) begin
          idx = ($urandom_range(0, 15) == 0) ? 7 : $urandom_range(0, 6);
          pick = $urandom_range(0, 9);
          dur = (pick < 6) ? 20'($urandom_range(1, 8)) : (pick < 8) ? 20'd0 : 20'($urandom);
          spd = ($urandom_range(0, 4) == 0);
          send(1'b0, idx[2:0], (idx < 7) ? legal_angle(idx) : 8'($urandom),
               dur, spd, k == loads - 1);
        end
        pick = $urandom_range(0, 10);
        tick_n(pick);
        sent += loads + pick;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send(1'b0, 3'd0, 8'd180, 20'd0, 1'b0, 1'b1);
    send(1'b0, 3'd6, 8'd200, 20'd0, 1'b0, 1'b1);
    send(1'b0, 3'd6, 8'd100, 20'd0, 1'b0, 1'b0);
    send(1'b0, 3'd1, 8'd95, 20'd0, 1'b0, 1'b0);
    send(1'b0, 3'd3, 8'd50, 20'd3, 1'b0, 1'b1);
    tick_n(4);
    send(1'b0, 3'd7, 8'd255, 20'd0, 1'b0, 1'b1);
    send(1'b0, 3'd2, 8'd180, 20'd0, 1'b1, 1'b1);
    tick_n(2);
    send(1'b0, 3'd4, 8'd255, 20'd0, 1'b0, 1'b1);
    tick_n(1);
    send(1'b0, 3'd4, 8'd70, 20'd0, 1'b0, 1'b1);
    send(1'b0, 3'd5, 8'd0, 20'hFFFFF, 1'b1, 1'b1);
    send(1'b0, 3'd5, 8'd120, 20'hFFFFF, 1'b0, 1'b1);
    tick_n(2);
    send(1'b0, 3'd5, 8'd120, 20'd0, 1'b0, 1'b1);
    tick_n(1);
    drain();

    write_reg(semi_pkg::REG_MIN_PACK, '0);
    write_reg(semi_pkg::REG_MAX_PACK, {7{8'd180}});
    write_reg(semi_pkg::REG_OFFSET_PACK, 56'({$urandom, $urandom}));
    write_reg(semi_pkg::REG_SPEED, 56'd1);
    write_reg(semi_pkg::REG_MIN_DUR, 56'd3);
    long_hold = 400;
    random_moves(15);
    drain();
    random_moves(10);
    drain();

    calm = 1'b1;
    write_reg(semi_pkg::REG_MIN_PACK, {7{8'hFF}});
    write_reg(semi_pkg::REG_MAX_PACK, '0);
    send(1'b0, 3'd0, 8'd0, 20'd0, 1'b0, 1'b1);
    send(1'b0, 3'd1, 8'd255, 20'd5, 1'b1, 1'b1);
    tick_n(2);
    drain();
    calm = 1'b0;

    write_reg(semi_pkg::REG_MIN_PACK, {8'($urandom_range(0, 60)), 48'h1E_0A_28_00_3C_14});
    write_reg(semi_pkg::REG_MAX_PACK, {8'($urandom_range(120, 255)), 48'hFF_B4_78_C8_96_FF});
    write_reg(semi_pkg::REG_OFFSET_PACK, 56'h7F807F807F807F);
    write_reg(semi_pkg::REG_SPEED, 56'd0);
    write_reg(semi_pkg::REG_MIN_DUR, 56'd0);
    random_moves(28);
    drain();

    write_reg(semi_pkg::REG_MIN_PACK, '0);
    write_reg(semi_pkg::REG_MAX_PACK, {7{8'hFF}});
    write_reg(semi_pkg::REG_OFFSET_PACK, 56'h807F807F807F80);
    write_reg(semi_pkg::REG_SPEED, 56'd255);
    write_reg(semi_pkg::REG_MIN_DUR, 56'd65535);
    random_moves(28);
    drain();

    if (fail_count == 0) begin
      $display("** servo_ease_motion_interpolator_top: PASSED **");
    end else begin
      $display("** servo_ease_motion_interpolator_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** servo_ease_motion_interpolator_top: FAILED **");
    $finish;
  end

endmodule

>>> filelist.f
rtl/semi_pkg.sv
rtl/semi_divider.sv
rtl/semi_datapath.sv
rtl/semi_ctrl.sv
rtl/servo_ease_motion_interpolator_top.sv
test/servo_ease_motion_checker.sv
test/tb_servo_ease_motion_interpolator_top.sv
